// ===== rtl/core/tprs_pkg.sv =====
package tprs_pkg;

  // Default sizes
  localparam int SLOTS_DEF       = 8;
  localparam int PACKET_BITS_DEF = 18;

  // Fixed field widths
  localparam int OP_W     = 3;
  localparam int SLOT_IN_W = 3;
  localparam int WORD_W   = 18;
  localparam int PAUSE_W  = 5;
  localparam int PERIOD_W = 14;
  localparam int HIGH_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // Bit-cell timing in timer counts
  localparam logic [HIGH_W-1:0] FAST_PERIOD = 9'd208;
  localparam logic [HIGH_W-1:0] SLOW_PERIOD = 9'd416;
  localparam logic [HIGH_W-1:0] HIGH_ONE    = 9'd182;
  localparam logic [HIGH_W-1:0] HIGH_ZERO   = 9'd26;

  // Pause reset values
  localparam logic [PAUSE_W-1:0] GAP_RESET  = 5'd3;
  localparam logic [PAUSE_W-1:0] WAIT_RESET = 5'd12;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd1;
  localparam logic [OP_W-1:0] OP_ENABLE   = 3'd2;
  localparam logic [OP_W-1:0] OP_DISABLE  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_FAST = 3'd4;
  localparam logic [OP_W-1:0] OP_SET_ONCE = 3'd5;
  localparam logic [OP_W-1:0] OP_START    = 3'd6;
  localparam logic [OP_W-1:0] OP_FAULT    = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_MESSAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FAST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_BITS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_BITS    = 2'd3;

endpackage

// ===== rtl/core/tprs_ifs.sv =====
// Request channel into the scheduler
interface tprs_in_if;
  logic                            valid;
  logic                            ready;
  logic [tprs_pkg::OP_W-1:0]      operation;
  logic [tprs_pkg::SLOT_IN_W-1:0] slot;
  logic [tprs_pkg::WORD_W-1:0]    message_word;
  logic                            flag;

  modport source (output valid, output operation, output slot, output message_word,
                  output flag, input ready);
  modport sink (input valid, input operation, input slot, input message_word,
                input flag, output ready);
endinterface

// Timing result channel out of the scheduler
interface tprs_out_if;
  logic                           valid;
  logic                           ready;
  logic                           timing_valid;
  logic [tprs_pkg::PERIOD_W-1:0] period_counts;
  logic [tprs_pkg::HIGH_W-1:0]   high_counts;
  logic                           rail_on;

  modport source (output valid, output timing_valid, output period_counts,
                  output high_counts, output rail_on, input ready);
  modport sink (input valid, input timing_valid, input period_counts,
                input high_counts, input rail_on, output ready);
endinterface

// ===== rtl/core/tprs_slot_pick.sv =====
// Round-robin pick: first enabled slot after the given one, wrapping.
module tprs_slot_pick #(
  parameter int SLOTS  = tprs_pkg::SLOTS_DEF,
  parameter int SLOT_W = $clog2(SLOTS)
) (
  input  logic [SLOTS-1:0]  enabled,
  input  logic [SLOT_W-1:0] after_slot,
  output logic              any,
  output logic [SLOT_W-1:0] pick
);

  logic [SLOT_W:0] first;

  // Search start, one past the current slot
  always_comb begin
    first = {1'b0, after_slot} + (SLOT_W+1)'(1);
    if (first >= (SLOT_W+1)'(SLOTS)) begin
      first = first - (SLOT_W+1)'(SLOTS);
    end
  end

  // Nearest enabled slot wins; walk from the far end so closer ones overwrite
  always_comb begin
    logic [SLOT_W:0] cand;
    any  = |enabled;
    pick = '0;
    cand = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      cand = first + (SLOT_W+1)'(k);
      if (cand >= (SLOT_W+1)'(SLOTS)) begin
        cand = cand - (SLOT_W+1)'(SLOTS);
      end
      if (enabled[cand[SLOT_W-1:0]]) begin
        pick = cand[SLOT_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/track_packet_repeat_scheduler.sv =====
// Track packet repeat scheduler. Takes one request per clock while the input is not
// stalled and returns exactly one result per request, in order, through the first-stage
// registers and then the output register. The packet slots live in a small synchronous
// memory with registered read data; the slot chosen on a packet change is read at
// acceptance and its word is merged in the second stage. A result waiting on the
// output lets one more request into the second stage; the input then stalls until
// that result is taken. A tick while running gives the period (pause included) and
// high time of the next bit cell; other operations return zero timing and the current
// rail state. No clearing pass is needed after reset; enabling a slot that was never
// written sends undefined bits.
module track_packet_repeat_scheduler #(
  parameter int SLOTS       = tprs_pkg::SLOTS_DEF,
  parameter int PACKET_BITS = tprs_pkg::PACKET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  tprs_in_if.sink                            in,
  tprs_out_if.source                         out,
  input  logic                               cfg_we,
  input  logic [tprs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tprs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int BP_W   = $clog2(PACKET_BITS);
  // one spare bit so that SLOTS itself fits in the range check
  localparam int IW     = ((SLOT_W > tprs_pkg::SLOT_IN_W) ? SLOT_W : tprs_pkg::SLOT_IN_W) + 1;
  localparam logic [BP_W-1:0] BP_LAST = BP_W'(PACKET_BITS - 1);

  // Configuration registers
  logic [tprs_pkg::WORD_W-1:0]  idle_message;
  logic                         idle_fast;
  logic [tprs_pkg::PAUSE_W-1:0] gap_bits;
  logic [tprs_pkg::PAUSE_W-1:0] wait_bits;

  // Scheduler state
  logic [PACKET_BITS-1:0] packet_store [SLOTS];
  logic [PACKET_BITS-1:0] mem_rdata;
  logic [SLOTS-1:0]       enabled_mask, enabled_mask_next;
  logic [SLOTS-1:0]       fast_mask, fast_mask_next;
  logic [SLOTS-1:0]       one_shot_mask, one_shot_mask_next;
  logic [SLOT_W-1:0]      current_slot, current_slot_next;
  logic [PACKET_BITS-1:0] current_packet;
  logic                   current_fast, current_fast_next;
  logic [BP_W-1:0]        bit_position, bit_position_next;
  logic                   second_copy, second_copy_next;
  logic                   running, running_next;

  // Second stage: waiting for the packet word
  logic                         s1_valid;
  logic                         s1_tick;
  logic [tprs_pkg::PERIOD_W-1:0] s1_period;
  logic [BP_W-1:0]              s1_bitpos;
  logic                         s1_fast;
  logic                         s1_load;
  logic                         s1_from_mem;
  logic                         s1_running;

  // Output register
  logic                          out_valid;
  logic                          out_timing;
  logic [tprs_pkg::PERIOD_W-1:0] out_period;
  logic [tprs_pkg::HIGH_W-1:0]   out_high;
  logic                          out_rail;

  // Front-end decode
  logic                   accept, advance;
  logic [IW-1:0]          slot_wide;
  logic                   slot_ok;
  logic [SLOT_W-1:0]      slot_idx;
  logic [SLOTS-1:0]       slot_bit;
  logic [SLOT_W-1:0]      pick_base;
  logic                   pick_any;
  logic [SLOT_W-1:0]      pick_slot;
  logic                   do_tick, do_load, mem_read;
  logic [tprs_pkg::HIGH_W-1:0]    base_period;
  logic [tprs_pkg::PAUSE_W:0]     pause_mult;
  logic [tprs_pkg::PERIOD_W-1:0]  period_calc;
  logic [PACKET_BITS-1:0] packet_eff;
  logic [tprs_pkg::HIGH_W-1:0]    high_calc;

  assign advance  = s1_valid && (!out_valid || out.ready);
  assign in.ready = !s1_valid || advance;
  assign accept   = in.valid && in.ready;

  // Slot address check
  assign slot_wide = IW'(in.slot);
  assign slot_ok   = slot_wide < IW'(SLOTS);
  assign slot_idx  = slot_wide[SLOT_W-1:0];
  assign slot_bit  = slot_ok ? (SLOTS'(1) << slot_idx) : '0;

  // Start searches from just after slot zero, so slot zero is tried last
  assign pick_base = (in.operation == tprs_pkg::OP_START) ? '0 : current_slot;

  tprs_slot_pick #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_pick (
    .enabled    (enabled_mask),
    .after_slot (pick_base),
    .any        (pick_any),
    .pick       (pick_slot)
  );

  // Cell period: base rate, stretched by the pause after the last bit
  always_comb begin
    base_period = current_fast ? tprs_pkg::FAST_PERIOD : tprs_pkg::SLOW_PERIOD;
    pause_mult  = {1'b0, (second_copy ? wait_bits : gap_bits)} + (tprs_pkg::PAUSE_W+1)'(1);
    if (bit_position == BP_LAST) begin
      period_calc = tprs_pkg::PERIOD_W'(base_period) * tprs_pkg::PERIOD_W'(pause_mult);
    end else begin
      period_calc = tprs_pkg::PERIOD_W'(base_period);
    end
  end

  // Next-state logic for one accepted request
  always_comb begin
    enabled_mask_next  = enabled_mask;
    fast_mask_next     = fast_mask;
    one_shot_mask_next = one_shot_mask;
    current_slot_next  = current_slot;
    current_fast_next  = current_fast;
    bit_position_next  = bit_position;
    second_copy_next   = second_copy;
    running_next       = running;
    do_tick            = 1'b0;
    do_load            = 1'b0;
    unique case (in.operation)
      tprs_pkg::OP_TICK: begin
        if (running) begin
          do_tick = 1'b1;
          if (bit_position == BP_LAST) begin
            bit_position_next = '0;
            second_copy_next  = !second_copy;
            do_load           = second_copy;
          end else begin
            bit_position_next = bit_position + BP_W'(1);
          end
        end
      end
      tprs_pkg::OP_WRITE: begin
      end
      tprs_pkg::OP_ENABLE:  enabled_mask_next = enabled_mask | slot_bit;
      tprs_pkg::OP_DISABLE: enabled_mask_next = enabled_mask & ~slot_bit;
      tprs_pkg::OP_SET_FAST: begin
        fast_mask_next = in.flag ? (fast_mask | slot_bit) : (fast_mask & ~slot_bit);
      end
      tprs_pkg::OP_SET_ONCE: begin
        one_shot_mask_next = in.flag ? (one_shot_mask | slot_bit)
                                     : (one_shot_mask & ~slot_bit);
      end
      tprs_pkg::OP_START: begin
        current_slot_next = '0;
        do_load           = 1'b1;
        bit_position_next = '0;
        second_copy_next  = 1'b0;
        running_next      = 1'b1;
      end
      tprs_pkg::OP_FAULT: running_next = 1'b0;
      default: begin
      end
    endcase
    // Packet change: round-robin pick, one-shot slots drop out; idle speed when no slot is enabled
    if (do_load) begin
      if (pick_any) begin
        current_slot_next = pick_slot;
        current_fast_next = fast_mask[pick_slot];
        if (one_shot_mask[pick_slot]) begin
          enabled_mask_next[pick_slot] = 1'b0;
        end
      end else begin
        current_fast_next = idle_fast;
      end
    end
  end

  assign mem_read = do_load && pick_any;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_message <= '0;
      idle_fast    <= 1'b0;
      gap_bits     <= tprs_pkg::GAP_RESET;
      wait_bits    <= tprs_pkg::WAIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tprs_pkg::CFG_IDLE_MESSAGE: idle_message <= cfg_data;
        tprs_pkg::CFG_IDLE_FAST:    idle_fast    <= cfg_data[0];
        tprs_pkg::CFG_GAP_BITS:     gap_bits     <= cfg_data[tprs_pkg::PAUSE_W-1:0];
        tprs_pkg::CFG_WAIT_BITS:    wait_bits    <= cfg_data[tprs_pkg::PAUSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Packet store: one access per request, read data held until the next read
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in.operation == tprs_pkg::OP_WRITE && slot_ok) begin
        packet_store[slot_idx] <= PACKET_BITS'(in.message_word);
      end else if (mem_read) begin
        mem_rdata <= packet_store[pick_slot];
      end
    end
  end

  // Control state and first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask  <= '0;
      fast_mask     <= '0;
      one_shot_mask <= '0;
      current_slot  <= '0;
      current_fast  <= 1'b0;
      bit_position  <= '0;
      second_copy   <= 1'b0;
      running       <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      if (accept) begin
        enabled_mask  <= enabled_mask_next;
        fast_mask     <= fast_mask_next;
        one_shot_mask <= one_shot_mask_next;
        current_slot  <= current_slot_next;
        current_fast  <= current_fast_next;
        bit_position  <= bit_position_next;
        second_copy   <= second_copy_next;
        running       <= running_next;
        s1_valid      <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tick     <= do_tick;
      s1_period   <= period_calc;
      s1_bitpos   <= bit_position_next;
      s1_fast     <= current_fast_next;
      s1_load     <= do_load;
      s1_from_mem <= pick_any;
      s1_running  <= running_next;
    end
  end

  // Second stage: merge the loaded packet and pick the high time
  always_comb begin
    if (s1_load) begin
      packet_eff = s1_from_mem ? mem_rdata : PACKET_BITS'(idle_message);
    end else begin
      packet_eff = current_packet;
    end
    high_calc = packet_eff[s1_bitpos] ? tprs_pkg::HIGH_ONE : tprs_pkg::HIGH_ZERO;
    if (!s1_fast) begin
      high_calc = {high_calc[tprs_pkg::HIGH_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_packet <= '0;
    end else if (advance && s1_load) begin
      current_packet <= packet_eff;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_timing <= s1_tick;
      out_period <= s1_tick ? s1_period : '0;
      out_high   <= s1_tick ? high_calc : '0;
      out_rail   <= s1_running;
    end
  end

  assign out.valid         = out_valid;
  assign out.timing_valid  = out_timing;
  assign out.period_counts = out_period;
  assign out.high_counts   = out_high;
  assign out.rail_on       = out_rail;

endmodule
